/* sv/ipv4bl_pkg.sv */
// ----------------------------------------------------------------------------
// ipv4bl_pkg
// shared constants and types for the ipv4 source blocklist
// ----------------------------------------------------------------------------
package ipv4bl_pkg;

	// table size and derived widths
	localparam int Capacity = 64;
	localparam int CntW     = $clog2(Capacity + 1);
	localparam int PrefixLvl = $clog2(Capacity);

	// field widths
	localparam int ModeW   = 2;
	localparam int AddrW   = 32;
	localparam int IdxW    = 6;
	localparam int StatusW = 2;
	localparam int OutCntW = 7;

	// stream word widths
	localparam int InDataW  = 40;
	localparam int OutDataW = 48;

	// item kinds
	localparam logic [ModeW-1:0] MODE_CHECK  = 2'd0;
	localparam logic [ModeW-1:0] MODE_ADD    = 2'd1;
	localparam logic [ModeW-1:0] MODE_DELETE = 2'd2;
	localparam logic [ModeW-1:0] MODE_READ   = 2'd3;

	// result status codes
	localparam logic [StatusW-1:0] ST_DONE      = 2'd0;
	localparam logic [StatusW-1:0] ST_DUPLICATE = 2'd1;
	localparam logic [StatusW-1:0] ST_ABSENT    = 2'd2;
	localparam logic [StatusW-1:0] ST_FULL      = 2'd3;

	// common control broadcast to every cell
	typedef struct packed {
		logic capture;
		logic add;
		logic del;
	} cell_ctl_t;

	// per-cell selects computed from the cell position
	typedef struct packed {
		logic in_use;
		logic write_sel;
		logic read_sel;
		logic shift_sel;
	} cell_sel_t;

endpackage

/* sv/ipv4_source_blocklist_core.sv */
// ----------------------------------------------------------------------------
// ipv4_source_blocklist_core
// blocklist of ipv4 source addresses kept in insertion order
// ----------------------------------------------------------------------------
// The table is a row of Capacity cells, each holding one address. Every
// input word carries a kind in tuser: packet check (drop if the address is
// held), add (append unless already held or the table is full), delete
// (remove and close the gap, each later cell taking its upper neighbor's
// word) or read (entry at an index with a valid flag). Every input word
// gives exactly one output word carrying the entry count after the item.
// An item is registered in the accepting cycle; in ST_CMP all cells
// compare it in parallel, and in ST_APPLY the match and read results
// are reduced, the row is updated and the output word is loaded. A new
// word is accepted only in ST_IDLE, so only one item is in flight at a
// time; a new word is accepted while the previous result still waits in
// the output register, and the update cycle waits only if that register
// is still full.
module ipv4_source_blocklist_core (
	input  logic                                clk,
	input  logic                                arst_n,
	// input stream
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// [31:0] address, [37:32] entry_index, [39:38] zero
	input  logic [ipv4bl_pkg::InDataW-1:0]      s_axis_tdata,
	// [1:0] mode
	input  logic [ipv4bl_pkg::ModeW-1:0]        s_axis_tuser,
	// result stream
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// [0] drop, [2:1] status, [34:3] entry_address, [35] entry_valid,
	// [42:36] entry_count, [47:43] zero
	output logic [ipv4bl_pkg::OutDataW-1:0]     m_axis_tdata
);

	localparam int Cap  = ipv4bl_pkg::Capacity;
	localparam int AW   = ipv4bl_pkg::AddrW;
	localparam int CW   = ipv4bl_pkg::CntW;
	localparam int IW   = ipv4bl_pkg::IdxW;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_APPLY
	} state_t;

	state_t                          state_q;
	logic [ipv4bl_pkg::ModeW-1:0]    mode_q;
	logic [AW-1:0]                   addr_q;
	logic [IW-1:0]                   idx_q;
	logic [CW-1:0]                   count_q;
	logic                            out_valid_q;
	logic [ipv4bl_pkg::OutDataW-1:0] out_data_q;

	// cell row
	ipv4bl_pkg::cell_ctl_t ctl;
	ipv4bl_pkg::cell_sel_t sel [Cap];
	logic [AW-1:0]         entry [Cap];
	logic [AW-1:0]         rdata [Cap];
	logic [Cap-1:0]        match;
	logic [Cap-1:0]        hit_below;

	// reduced results
	logic          hit;
	logic          full;
	logic [AW-1:0] rd_word;
	logic          rd_valid;
	logic          fire;
	logic          do_add;
	logic          do_del;
	logic [CW-1:0] new_count;
	logic [ipv4bl_pkg::StatusW-1:0] status;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// update cycle proceeds once the output register is free
	assign fire = (state_q == ST_APPLY) && (!out_valid_q || m_axis_tready);

	assign hit  = |match;
	assign full = (count_q == CW'(Cap));

	assign do_add = fire && (mode_q == ipv4bl_pkg::MODE_ADD) && !hit && !full;
	assign do_del = fire && (mode_q == ipv4bl_pkg::MODE_DELETE) && hit;

	assign ctl.capture = (state_q == ST_CMP);
	assign ctl.add     = do_add;
	assign ctl.del     = do_del;

	// cells at or above the matching slot shift down on delete
	always_comb begin
		hit_below = match;
		for (int k = 0; k < ipv4bl_pkg::PrefixLvl; k++) begin
			hit_below = hit_below | (hit_below << (1 << k));
		end
	end

	// read data: only the selected cell drives a non-zero word
	always_comb begin
		rd_word = '0;
		for (int i = 0; i < Cap; i++) begin
			rd_word = rd_word | rdata[i];
		end
	end

	assign rd_valid = (mode_q == ipv4bl_pkg::MODE_READ)
		&& (32'(idx_q) < 32'(count_q)) && (32'(idx_q) < 32'(Cap));

	always_comb begin
		new_count = count_q;
		if (do_add) begin
			new_count = count_q + CW'(1);
		end else if (do_del) begin
			new_count = count_q - CW'(1);
		end
	end

	always_comb begin
		case (mode_q)
			ipv4bl_pkg::MODE_ADD: begin
				if (hit) begin
					status = ipv4bl_pkg::ST_DUPLICATE;
				end else if (full) begin
					status = ipv4bl_pkg::ST_FULL;
				end else begin
					status = ipv4bl_pkg::ST_DONE;
				end
			end
			ipv4bl_pkg::MODE_DELETE: begin
				status = hit ? ipv4bl_pkg::ST_DONE : ipv4bl_pkg::ST_ABSENT;
			end
			default: begin
				status = ipv4bl_pkg::ST_DONE;
			end
		endcase
	end

	genvar gi;
	generate
		for (gi = 0; gi < Cap; gi++) begin : g_cell
			logic [AW-1:0] next_entry;

			if (gi == Cap - 1) begin : g_top
				assign next_entry = '0;
			end else begin : g_mid
				assign next_entry = entry[gi + 1];
			end

			assign sel[gi].in_use    = (32'(gi) < 32'(count_q));
			assign sel[gi].write_sel = (32'(gi) == 32'(count_q));
			assign sel[gi].read_sel  = (32'(gi) == 32'(idx_q));
			assign sel[gi].shift_sel = hit_below[gi];

			ipv4bl_cell u_cell (
				.clk        (clk),
				.ctl        (ctl),
				.sel        (sel[gi]),
				.key        (addr_q),
				.next_entry (next_entry),
				.entry      (entry[gi]),
				.match      (match[gi]),
				.rdata      (rdata[gi])
			);
		end
	endgenerate

	// sequencer, held count and output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// a new word loaded in the same cycle keeps the register full
			if (out_valid_q && m_axis_tready && !fire) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					state_q <= ST_APPLY;
				end
				ST_APPLY: begin
					if (fire) begin
						state_q     <= ST_IDLE;
						count_q     <= new_count;
						out_valid_q <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// item and result payload
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			mode_q <= s_axis_tuser;
			addr_q <= s_axis_tdata[AW-1:0];
			idx_q  <= s_axis_tdata[AW+IW-1:AW];
		end
		if (fire) begin
			out_data_q <= {
				5'd0,
				ipv4bl_pkg::OutCntW'(new_count),
				rd_valid,
				rd_valid ? rd_word : '0,
				status,
				(mode_q == ipv4bl_pkg::MODE_CHECK) && hit
			};
		end
	end

endmodule

/* sv/ipv4bl_cell.sv */
// ----------------------------------------------------------------------------
// ipv4bl_cell
// one table slot: holds an address, compares it, shifts down on delete
// ----------------------------------------------------------------------------
module ipv4bl_cell (
	input  logic                          clk,
	input  ipv4bl_pkg::cell_ctl_t         ctl,
	input  ipv4bl_pkg::cell_sel_t         sel,
	input  logic [ipv4bl_pkg::AddrW-1:0]  key,
	input  logic [ipv4bl_pkg::AddrW-1:0]  next_entry,
	output logic [ipv4bl_pkg::AddrW-1:0]  entry,
	output logic                          match,
	output logic [ipv4bl_pkg::AddrW-1:0]  rdata
);

	logic [ipv4bl_pkg::AddrW-1:0] entry_q;
	logic                         match_q;
	logic [ipv4bl_pkg::AddrW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			match_q <= sel.in_use && (entry_q == key);
			rdata_q <= (sel.in_use && sel.read_sel) ? entry_q : '0;
		end
		// append at the fill position, or take the upper neighbor's word
		if (ctl.add && sel.write_sel) begin
			entry_q <= key;
		end else if (ctl.del && sel.shift_sel) begin
			entry_q <= next_entry;
		end
	end

	assign entry = entry_q;
	assign match = match_q;
	assign rdata = rdata_q;

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// stream-level test of the ipv4 source blocklist core
// ----------------------------------------------------------------------------
// A queue of request words is filled up front: a short directed run over the
// empty, single-entry and edge cases, then random episodes that fill the
// table to capacity, drain it, mix all four kinds and throw in noise. A
// clocked driver sends the words with random gaps, and a clocked monitor
// takes results with random stalls. Each accepted word is run through a
// local blocklist model, and each result is compared field by field with
// the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
	import ipv4bl_pkg::*;

	localparam int QuietLimit = 2000;
	localparam int RandomWords = 400;
	localparam int PoolSize = 48;

	// one request word
	typedef struct {
		logic [ModeW-1:0] mode;
		logic [AddrW-1:0] addr;
		logic [IdxW-1:0]  idx;
	} request_t;

	// one result word, packed in the order of m_axis_tdata from bit 42 down to bit 0
	typedef struct packed {
		logic [OutCntW-1:0] count;
		logic               valid;
		logic [AddrW-1:0]   entry;
		logic [StatusW-1:0] status;
		logic               drop;
	} verdict_t;

	// blocklist contents in insertion order
	typedef struct {
		logic [AddrW-1:0] slot [Capacity];
		int               held;
	} blocklist_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [InDataW-1:0]  s_axis_tdata = '0;
	logic [ModeW-1:0]    s_axis_tuser = MODE_CHECK;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [OutDataW-1:0] m_axis_tdata;

	request_t   pending_words [$];
	verdict_t   expected_results [$];
	blocklist_t plan_list;   // follows the words as they are queued
	blocklist_t live_list;   // follows the words as they are accepted
	logic [AddrW-1:0] addr_pool [PoolSize];

	request_t in_flight;
	int send_gap = 0;
	int send_calm = 0;
	int recv_stall = 0;
	int recv_calm = 0;
	int quiet_cycles = 0;
	int mismatches = 0;
	int results_checked = 0;
	int words_seen [4] = '{0, 0, 0, 0};
	int drops_seen = 0;
	int full_refusals = 0;
	int peak_held = 0;

	ipv4_source_blocklist_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// position of addr among the held entries, or held if absent
	function automatic int find_slot(input blocklist_t t, input logic [AddrW-1:0] addr);
		for (int i = 0; i < t.held; i++) begin
			if (t.slot[i] == addr) return i;
		end
		return t.held;
	endfunction

	// apply one request to a blocklist and give the result word it causes
	function automatic verdict_t blocklist_step(inout blocklist_t t, input request_t r);
		verdict_t v;
		int pos;
		v = '0;
		pos = find_slot(t, r.addr);
		case (r.mode)
			MODE_CHECK: begin
				v.drop = (pos < t.held);
			end
			MODE_ADD: begin
				// a held address reports duplicate even on a full table
				if (pos < t.held) begin
					v.status = ST_DUPLICATE;
				end else if (t.held >= Capacity) begin
					v.status = ST_FULL;
				end else begin
					t.slot[t.held] = r.addr;
					t.held++;
				end
			end
			MODE_DELETE: begin
				if (pos >= t.held) begin
					v.status = ST_ABSENT;
				end else begin
					// close the gap so insertion order is kept
					for (int i = pos; i + 1 < t.held; i++) t.slot[i] = t.slot[i + 1];
					t.held--;
				end
			end
			default: begin
				if (int'(r.idx) < t.held) begin
					v.valid = 1'b1;
					v.entry = t.slot[r.idx];
				end
			end
		endcase
		v.count = t.held[OutCntW-1:0];
		return v;
	endfunction

	task automatic queue_word(input logic [ModeW-1:0] mode, input logic [AddrW-1:0] addr,
			input logic [IdxW-1:0] idx);
		request_t r;
		r.mode = mode;
		r.addr = addr;
		r.idx  = idx;
		pending_words.push_back(r);
		void'(blocklist_step(plan_list, r));
	endtask

	function automatic logic [AddrW-1:0] held_addr();
		return plan_list.slot[$urandom_range(0, plan_list.held - 1)];
	endfunction

	function automatic logic [AddrW-1:0] pool_addr();
		return addr_pool[$urandom_range(0, PoolSize - 1)];
	endfunction

	function automatic logic [IdxW-1:0] any_idx();
		return IdxW'($urandom_range(0, Capacity - 1));
	endfunction

	// wait length per word, with calm stretches that have no idling at all
	function automatic int draw_wait(inout int calm_left);
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		if ($urandom_range(0, 29) == 0) begin
			calm_left = $urandom_range(10, 40);
			return 0;
		end
		return ($urandom_range(0, 1) == 1) ? int'($urandom_range(0, 18)) : 0;
	endfunction

	task automatic report_fault(input string msg);
		mismatches++;
		if (mismatches <= 10) $display("mismatch: %s", msg);
	endtask

	task automatic check_field(input string name, input logic [AddrW-1:0] want,
			input logic [AddrW-1:0] got);
		if (got !== want)
			report_fault($sformatf("%s expected 0x%0h, got 0x%0h", name, want, got));
	endtask

	// driver: presents queued words, draws a gap after each accepted one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			s_axis_tuser  <= MODE_CHECK;
			send_gap = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				verdict_t v;
				v = blocklist_step(live_list, in_flight);
				expected_results.push_back(v);
				words_seen[in_flight.mode]++;
				if (v.drop) drops_seen++;
				if (in_flight.mode == MODE_ADD && v.status == ST_FULL) full_refusals++;
				if (live_list.held > peak_held) peak_held = live_list.held;
				send_gap = draw_wait(send_calm);
			end
			// only move on once the current word is gone
			if (!(s_axis_tvalid && !s_axis_tready)) begin
				if (send_gap > 0) begin
					send_gap--;
					s_axis_tvalid <= 1'b0;
				end else if (pending_words.size() > 0) begin
					in_flight = pending_words.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= {2'b00, in_flight.idx, in_flight.addr};
					s_axis_tuser  <= in_flight.mode;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor: takes result words, stalls at random after each one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			recv_stall = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				verdict_t want;
				verdict_t got;
				got = m_axis_tdata[$bits(verdict_t)-1:0];
				if (expected_results.size() == 0) begin
					report_fault($sformatf("result 0x%0h with nothing outstanding", m_axis_tdata));
				end else begin
					want = expected_results.pop_front();
					results_checked++;
					check_field("drop", AddrW'(want.drop), AddrW'(got.drop));
					check_field("status", AddrW'(want.status), AddrW'(got.status));
					check_field("entry_address", want.entry, got.entry);
					check_field("entry_valid", AddrW'(want.valid), AddrW'(got.valid));
					check_field("entry_count", AddrW'(want.count), AddrW'(got.count));
				end
				recv_stall = draw_wait(recv_calm);
			end
			if (recv_stall > 0) begin
				recv_stall--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// watchdog on cycles with no handshake on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QuietLimit) begin
				$display("timeout after %0d quiet cycles", quiet_cycles);
				$display("ipv4_source_blocklist_core verification failed");
				$finish;
			end
		end
	end

	initial begin
		int start_words;
		int total_words;
		int episode;
		int pick;
		int target;
		plan_list.held = 0;
		live_list.held = 0;
		for (int i = 0; i < Capacity; i++) begin
			plan_list.slot[i] = '0;
			live_list.slot[i] = '0;
		end
		addr_pool[0] = '0;
		addr_pool[1] = '1;
		for (int i = 2; i < PoolSize; i++) addr_pool[i] = $urandom();

		// directed: empty table, duplicates, head and tail removal, reads past the count
		queue_word(MODE_CHECK, 32'h0000_0000, '0);
		queue_word(MODE_READ, 32'h0000_0000, '0);
		queue_word(MODE_READ, 32'hFFFF_FFFF, '1);
		queue_word(MODE_DELETE, 32'hFFFF_FFFF, '0);
		queue_word(MODE_ADD, 32'h0000_0000, '0);
		queue_word(MODE_ADD, 32'hFFFF_FFFF, '1);
		queue_word(MODE_ADD, 32'hFFFF_FFFF, '0);
		queue_word(MODE_ADD, 32'h8000_0001, '0);
		queue_word(MODE_CHECK, 32'hFFFF_FFFF, '0);
		queue_word(MODE_CHECK, 32'h0000_0000, '1);
		queue_word(MODE_CHECK, 32'h7FFF_FFFE, '0);
		for (int i = 0; i < 4; i++) queue_word(MODE_READ, 32'h5A5A_A5A5, IdxW'(i));
		queue_word(MODE_DELETE, 32'h0000_0000, '0);
		queue_word(MODE_READ, 32'h0000_0000, 6'd0);
		queue_word(MODE_READ, 32'h0000_0000, 6'd1);
		queue_word(MODE_DELETE, 32'h1234_5678, '0);
		queue_word(MODE_DELETE, 32'h8000_0001, '0);
		queue_word(MODE_DELETE, 32'hFFFF_FFFF, '0);
		queue_word(MODE_READ, 32'hFFFF_FFFF, 6'd0);

		// random episodes; the first one always fills the table
		start_words = pending_words.size();
		episode = 0;
		while (pending_words.size() - start_words < RandomWords) begin
			pick = (episode == 0) ? 0 : $urandom_range(0, 5);
			case (pick)
				0, 1: begin
					// fill to capacity, then hit the full table from every side
					while (plan_list.held < Capacity) begin
						if ($urandom_range(0, 99) < 85)
							queue_word(MODE_ADD,
								($urandom_range(0, 3) == 0) ? pool_addr() : $urandom(), any_idx());
						else
							queue_word(MODE_CHECK, pool_addr(), any_idx());
					end
					queue_word(MODE_ADD, $urandom(), any_idx());
					queue_word(MODE_ADD, held_addr(), any_idx());
					queue_word(MODE_READ, $urandom(), '1);
					queue_word(MODE_READ, $urandom(), '0);
					queue_word(MODE_CHECK, held_addr(), any_idx());
					queue_word(MODE_DELETE, held_addr(), any_idx());
					queue_word(MODE_ADD, $urandom(), any_idx());
					queue_word(MODE_ADD, $urandom(), any_idx());
				end
				2: begin
					// drain down to at most eight entries, mostly by deleting held entries
					target = $urandom_range(0, 8);
					while (plan_list.held > target) begin
						pick = $urandom_range(0, 99);
						if (pick < 75)
							queue_word(MODE_DELETE, held_addr(), any_idx());
						else if (pick < 85)
							queue_word(MODE_DELETE, $urandom(), any_idx());
						else
							queue_word(MODE_READ, $urandom(), any_idx());
					end
				end
				3, 4: begin
					// all four kinds mixed, with hits drawn from the held entries
					for (int n = 0; n < 40; n++) begin
						pick = $urandom_range(0, 99);
						if (pick < 25)
							queue_word(MODE_CHECK, (plan_list.held > 0 && $urandom_range(0, 1) == 1)
								? held_addr() : pool_addr(), any_idx());
						else if (pick < 50)
							queue_word(MODE_ADD, pool_addr(), any_idx());
						else if (pick < 70)
							queue_word(MODE_DELETE, (plan_list.held > 0 && $urandom_range(0, 1) == 1)
								? held_addr() : pool_addr(), any_idx());
						else if (plan_list.held > 0 && $urandom_range(0, 1) == 1)
							queue_word(MODE_READ, $urandom(),
								IdxW'($urandom_range(0, plan_list.held - 1)));
						else
							queue_word(MODE_READ, $urandom(), any_idx());
					end
				end
				default: begin
					// noise: every field fully random
					for (int n = 0; n < 10; n++)
						queue_word(ModeW'($urandom_range(0, 3)), $urandom(), any_idx());
				end
			endcase
			episode++;
		end
		total_words = pending_words.size();

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// run until every queued word has come back as a result, then let it settle
		do begin
			@(posedge clk);
		end while (results_checked < total_words);
		repeat (20) @(posedge clk);
		if (expected_results.size() > 0)
			report_fault($sformatf("%0d results never arrived", expected_results.size()));

		$display("covered %0d words: %0d checks (%0d dropped), %0d adds, %0d deletes, %0d reads",
			words_seen[0] + words_seen[1] + words_seen[2] + words_seen[3], words_seen[MODE_CHECK],
			drops_seen, words_seen[MODE_ADD], words_seen[MODE_DELETE], words_seen[MODE_READ]);
		$display("peak fill %0d of %0d, %0d adds refused on a full table, %0d mismatches",
			peak_held, Capacity, full_refusals, mismatches);
		if (mismatches == 0) begin
			$display("ipv4_source_blocklist_core verification clean");
		end else begin
			$display("ipv4_source_blocklist_core verification failed");
		end
		$finish;
	end

endmodule
